/* rtl/efd_pkg.sv */
package efd_pkg;

  localparam int unsigned COUNT_BITS_DEF = 16;

  localparam logic [7:0] MARK_START = 8'h3e;
  localparam logic [7:0] MARK_END   = 8'h3c;
  localparam logic [7:0] MARK_ESC   = 8'h3d;
  localparam logic [7:0] ESC_3C     = 8'h2c;
  localparam logic [7:0] ESC_3D     = 8'h2d;
  localparam logic [7:0] ESC_3E     = 8'h2e;

  localparam int unsigned HDR_PLUS_SUM = 7;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_BAD_ESC = 3'd1,
    ST_SHORT   = 3'd2,
    ST_BAD_SUM = 3'd3,
    ST_LEN     = 3'd4
  } status_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data;
    logic [15:0] payload_index;
    logic [7:0]  frame_type;
    logic [7:0]  frame_seq;
    status_t     status;
    logic        last;
  } result_t;

endpackage

/* rtl/efd_core.sv */
module efd_core #(
  parameter int unsigned COUNT_BITS = efd_pkg::COUNT_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              take,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output efd_pkg::result_t  res
);

  localparam int unsigned CW = COUNT_BITS + 1;
  localparam logic [CW-1:0] CNT_MAX = {CW{1'b1}};
  localparam logic [CW-1:0] CNT_HDR = CW'(efd_pkg::HDR_PLUS_SUM);

  logic          in_frame_r, in_frame_nxt;
  logic          esc_pend_r, esc_pend_nxt;
  logic          esc_err_r,  esc_err_nxt;
  logic [CW-1:0] count_r,    count_nxt;
  logic [7:0]    held_r,     held_nxt;
  logic [7:0]    sum_r,      sum_nxt;
  logic [7:0]    type_r,     type_nxt;
  logic [7:0]    seq_r,      seq_nxt;
  logic [31:0]   decl_r,     decl_nxt;

  logic          dec_valid;
  logic [7:0]    dec_byte;
  logic          end_seen;
  logic [CW-1:0] idx_full;
  logic [CW+15:0] idx_ext;
  logic [33:0]   cnt_wide;
  logic [33:0]   len_want;
  efd_pkg::status_t st;

  assign idx_full = count_r - CNT_HDR;
  assign idx_ext  = {16'b0, idx_full};
  assign cnt_wide = 34'(count_r);
  assign len_want = 34'(decl_r) + 34'(efd_pkg::HDR_PLUS_SUM);

  // byte decode and escape handling
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_pend_nxt = esc_pend_r;
    esc_err_nxt  = esc_err_r;
    dec_valid    = 1'b0;
    dec_byte     = rx_byte;
    end_seen     = 1'b0;
    if (!in_frame_r) begin
      if (rx_byte == efd_pkg::MARK_START) begin
        in_frame_nxt = 1'b1;
        esc_pend_nxt = 1'b0;
        esc_err_nxt  = 1'b0;
      end
    end else if (rx_byte == efd_pkg::MARK_END) begin
      end_seen     = 1'b1;
      in_frame_nxt = 1'b0;
      esc_pend_nxt = 1'b0;
    end else if (esc_err_r) begin
      dec_valid = 1'b0;
    end else if (esc_pend_r) begin
      esc_pend_nxt = 1'b0;
      unique case (rx_byte)
        efd_pkg::ESC_3C: begin dec_valid = 1'b1; dec_byte = efd_pkg::MARK_END;   end
        efd_pkg::ESC_3D: begin dec_valid = 1'b1; dec_byte = efd_pkg::MARK_ESC;   end
        efd_pkg::ESC_3E: begin dec_valid = 1'b1; dec_byte = efd_pkg::MARK_START; end
        default:         esc_err_nxt = 1'b1;
      endcase
    end else if (rx_byte == efd_pkg::MARK_ESC) begin
      esc_pend_nxt = 1'b1;
    end else begin
      dec_valid = 1'b1;
    end
  end

  // body bookkeeping
  always_comb begin
    count_nxt = count_r;
    held_nxt  = held_r;
    sum_nxt   = sum_r;
    type_nxt  = type_r;
    seq_nxt   = seq_r;
    decl_nxt  = decl_r;
    if (!in_frame_r && rx_byte == efd_pkg::MARK_START) begin
      count_nxt = '0;
      held_nxt  = '0;
      sum_nxt   = '0;
      type_nxt  = '0;
      seq_nxt   = '0;
      decl_nxt  = '0;
    end else if (dec_valid) begin
      if (count_r == CW'(0)) type_nxt = dec_byte;
      else if (count_r == CW'(1)) seq_nxt = dec_byte;
      else if (count_r <= CW'(5)) decl_nxt = {decl_r[23:0], dec_byte};
      if (count_r != CW'(0)) sum_nxt = sum_r + held_r;
      held_nxt = dec_byte;
      if (count_r != CNT_MAX) count_nxt = count_r + CW'(1);
    end
  end

  always_comb begin
    if (esc_err_r || esc_pend_r)          st = efd_pkg::ST_BAD_ESC;
    else if (count_r < CNT_HDR)           st = efd_pkg::ST_SHORT;
    else if (sum_r != held_r)             st = efd_pkg::ST_BAD_SUM;
    else if (count_r == CNT_MAX || cnt_wide != len_want) st = efd_pkg::ST_LEN;
    else                                  st = efd_pkg::ST_OK;
  end

  always_comb begin
    res            = '0;
    res.frame_type = type_nxt;
    res.frame_seq  = seq_nxt;
    res_valid      = 1'b0;
    if (end_seen) begin
      res_valid  = 1'b1;
      res.kind   = efd_pkg::KIND_STATUS;
      res.status = st;
      res.last   = 1'b1;
    end else if (dec_valid && count_r >= CNT_HDR && count_r != CNT_MAX) begin
      res_valid         = 1'b1;
      res.kind          = efd_pkg::KIND_DATA;
      res.data          = held_r;
      res.payload_index = idx_ext[15:0];
      res.status        = efd_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_pend_r <= 1'b0;
      esc_err_r  <= 1'b0;
      count_r    <= '0;
      held_r     <= '0;
      sum_r      <= '0;
      type_r     <= '0;
      seq_r      <= '0;
      decl_r     <= '0;
    end else if (take) begin
      in_frame_r <= in_frame_nxt;
      esc_pend_r <= esc_pend_nxt;
      esc_err_r  <= esc_err_nxt;
      count_r    <= count_nxt;
      held_r     <= held_nxt;
      sum_r      <= sum_nxt;
      type_r     <= type_nxt;
      seq_r      <= seq_nxt;
      decl_r     <= decl_nxt;
    end
  end

endmodule

/* rtl/escaped_frame_deframer.sv */
// Byte-stuffed frame receiver. Takes one raw byte per cycle and gives at most
// one result per byte: decoded payload bytes (delayed by one byte, so the sum
// byte never appears) and one status result per end marker. Each accepted
// byte is decoded in the cycle it is taken; its result sits in the output
// register from the next cycle on. in_ready is high whenever that register is
// empty or being drained this cycle, so sustained rate is one byte per clock
// while out_ready stays high. in_ready depends combinationally on out_ready.
module escaped_frame_deframer #(
  parameter int unsigned COUNT_BITS = efd_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_data,
  output logic [15:0] out_payload_index,
  output logic [7:0]  out_frame_type,
  output logic [7:0]  out_frame_seq,
  output logic [2:0]  out_status,
  output logic        out_last
);

  logic             take;
  logic             res_valid;
  efd_pkg::result_t res;
  efd_pkg::result_t out_r;
  logic             out_valid_r;

  assign in_ready = !out_valid_r || out_ready;
  assign take     = in_valid && in_ready;

  efd_core #(
    .COUNT_BITS(COUNT_BITS)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .rx_byte  (in_rx_byte),
    .res_valid(res_valid),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take && res_valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_r.kind;
  assign out_data          = out_r.data;
  assign out_payload_index = out_r.payload_index;
  assign out_frame_type    = out_r.frame_type;
  assign out_frame_seq     = out_r.frame_seq;
  assign out_status        = out_r.status;
  assign out_last          = out_r.last;

  a_status_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == efd_pkg::KIND_STATUS |->
      out_last && out_data == 8'd0 && out_payload_index == 16'd0)
    else $error("status request carries payload");

  a_data_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == efd_pkg::KIND_DATA |->
      !out_last && out_status == efd_pkg::ST_OK)
    else $error("payload request carries status");

  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("pending request dropped");

endmodule
